/* sv/dtq_pkg.sv */
// Shared types and constants of the drop-tail descriptor queue with flow counters.
package dtq_pkg;

  localparam int FLOW_IDS = 64;

  localparam logic [1:0] FUNC_ENQ   = 2'd0;
  localparam logic [1:0] FUNC_DEQ   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic KIND_INTEREST = 1'b0;
  localparam logic KIND_CONTENT  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DROP  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic [1:0] REG_LIMIT_MODE  = 2'd0;
  localparam logic [1:0] REG_MAX_PACKETS = 2'd1;
  localparam logic [1:0] REG_MAX_BYTES   = 2'd2;

  localparam logic        LIMIT_PACKETS   = 1'b0;
  localparam logic [7:0]  RST_MAX_PACKETS = 8'd100;
  localparam logic [23:0] RST_MAX_BYTES   = 24'(100 * 65535);

  typedef struct packed {
    logic [1:0]  func;
    logic        kind;
    logic        nack_flag;
    logic [5:0]  flow_id;
    logic [15:0] pkt_length;
    logic [15:0] pkt_tag;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_tag;
    logic [15:0] out_length;
    logic [5:0]  out_flow;
    logic [7:0]  flow_count;
    logic [6:0]  flows_seen;
  } out_word_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] length;
    logic [5:0]  flow;
  } desc_t;

  typedef struct packed {
    logic       present;
    logic [7:0] count;
  } flow_entry_t;

endpackage

/* sv/dtq_ram.sv */
// Synchronous single-write, single-read memory with registered read data.
module dtq_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/drop_tail_queue_flow_count_top.sv */
// Top level of the drop-tail descriptor queue with per-flow occupancy counters.
//
// Input words carry a function code: enqueue, dequeue or flow counter query. Every
// accepted word gives exactly one result word on the output channel, in order.
// Descriptors live in a QUEUE_DEPTH-entry memory and flow counters in a FLOW_COUNT-entry
// memory; each word is handled by reading those memories, then writing at most one entry
// of each. An enqueue or query word, or a dequeue of an empty queue, goes from idle
// straight to the execute state, where its result is registered; a dequeue of a non-empty
// queue first passes through a flow-read state, since the flow entry to update is only
// known once the head descriptor has been read. The block works on one word at a time
// and takes no new word until the result of the last one has been loaded.
// A result waits in the output register while out_stall is high; meanwhile the
// next input word can be accepted and held until the output register is free.
// After reset the flow counter memory is cleared entry by entry while in_stall stays
// high; the limits return to 100 packets and 6553500 bytes in packet mode. The user
// must write the limit registers over the APB port only while idle; the block does not enforce it.
module drop_tail_queue_flow_count_top
  import dtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 128,
  parameter int FLOW_COUNT  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int SC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int FIDX_W = $clog2(FLOW_COUNT);
  localparam int BT_W   = SC_W + 16;
  localparam int CMP_W  = (BT_W + 1 > 24) ? BT_W + 1 : 24;
  localparam int PK_W   = (SC_W > 8) ? SC_W : 8;
  localparam int DESC_W = $bits(desc_t);
  localparam int FENT_W = $bits(flow_entry_t);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_FLOW  = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [FIDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [SC_W-1:0]   stored_r, stored_nxt;
  logic [BT_W-1:0]   bytes_r, bytes_nxt;
  logic [6:0]        present_total_r, present_total_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r;
  in_word_t          req_r;
  logic [FIDX_W-1:0] flow_idx_r;

  logic              limit_mode_r;
  logic [7:0]        max_packets_r;
  logic [23:0]       max_bytes_r;

  logic [FIDX_W-1:0] fidx_lut [FLOW_IDS];

  logic              desc_we, desc_re;
  desc_t             desc_wdata, desc_rd;
  logic [DESC_W-1:0] desc_rdata;
  logic              flow_we, flow_re;
  logic [FIDX_W-1:0] flow_waddr, flow_raddr;
  flow_entry_t       flow_wdata, flow_rd;
  logic [FENT_W-1:0] flow_rdata;

  logic              accept, out_free, out_load, cfg_write;
  logic              over_limit, full, empty;
  out_word_t         res;

  genvar g;
  generate
    for (g = 0; g < FLOW_IDS; g++) begin : g_fidx
      assign fidx_lut[g] = FIDX_W'(g % FLOW_COUNT);
    end
  endgenerate

  dtq_ram #(
    .WIDTH (DESC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_desc_ram (
    .clk   (clk),
    .we    (desc_we),
    .waddr (tail_r),
    .wdata (desc_wdata),
    .re    (desc_re),
    .raddr (head_r),
    .rdata (desc_rdata)
  );

  dtq_ram #(
    .WIDTH (FENT_W),
    .DEPTH (FLOW_COUNT)
  ) u_flow_ram (
    .clk   (clk),
    .we    (flow_we),
    .waddr (flow_waddr),
    .wdata (flow_wdata),
    .re    (flow_re),
    .raddr (flow_raddr),
    .rdata (flow_rdata)
  );

  assign desc_rd  = desc_t'(desc_rdata);
  assign flow_rd  = flow_entry_t'(flow_rdata);
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign full  = (stored_r >= SC_W'(QUEUE_DEPTH));
  assign empty = (stored_r == '0);

  always_comb begin
    if (limit_mode_r == LIMIT_PACKETS) begin
      over_limit = (PK_W'(stored_r) >= PK_W'(max_packets_r));
    end else begin
      over_limit = (CMP_W'(bytes_r) + CMP_W'(req_r.pkt_length)) >= CMP_W'(max_bytes_r);
    end
  end

  always_comb begin
    state_nxt         = state_r;
    clr_idx_nxt       = clr_idx_r;
    head_nxt          = head_r;
    tail_nxt          = tail_r;
    stored_nxt        = stored_r;
    bytes_nxt         = bytes_r;
    present_total_nxt = present_total_r;
    desc_we           = 1'b0;
    desc_re           = 1'b0;
    desc_wdata        = '{tag: req_r.pkt_tag, length: req_r.pkt_length, flow: req_r.flow_id};
    flow_we           = 1'b0;
    flow_re           = 1'b0;
    flow_raddr        = fidx_lut[in_data.flow_id];
    flow_waddr        = flow_idx_r;
    flow_wdata        = flow_rd;
    out_load          = 1'b0;
    res               = '0;
    case (state_r)
      ST_CLEAR: begin
        flow_we     = 1'b1;
        flow_waddr  = clr_idx_r;
        flow_wdata  = '0;
        clr_idx_nxt = clr_idx_r + FIDX_W'(1);
        if (clr_idx_r == FIDX_W'(FLOW_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          desc_re = 1'b1;
          flow_re = 1'b1;
          if (in_data.func == FUNC_DEQ && !empty) begin
            state_nxt = ST_FLOW;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_FLOW: begin
        flow_re    = 1'b1;
        flow_raddr = fidx_lut[desc_rd.flow];
        state_nxt  = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          case (req_r.func)
            FUNC_ENQ: begin
              if (req_r.kind == KIND_CONTENT) begin
                if (full || over_limit) begin
                  res.status = STATUS_DROP;
                end else begin
                  desc_we    = 1'b1;
                  tail_nxt   = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
                  stored_nxt = stored_r + SC_W'(1);
                  bytes_nxt  = bytes_r + BT_W'(req_r.pkt_length);
                  flow_we    = 1'b1;
                  if (!flow_rd.present) begin
                    flow_wdata        = '{present: 1'b1, count: 8'd1};
                    present_total_nxt = present_total_r + 7'd1;
                  end else if ({1'b0, flow_rd.count} + 9'd1 <= {1'b0, max_packets_r}) begin
                    flow_wdata.count = flow_rd.count + 8'd1;
                  end
                end
              end else if (!req_r.nack_flag && over_limit) begin
                res.status = STATUS_DROP;
              end
            end
            FUNC_DEQ: begin
              if (empty) begin
                res.status = STATUS_EMPTY;
              end else begin
                res.out_tag    = desc_rd.tag;
                res.out_length = desc_rd.length;
                res.out_flow   = desc_rd.flow;
                head_nxt   = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
                stored_nxt = stored_r - SC_W'(1);
                bytes_nxt  = bytes_r - BT_W'(desc_rd.length);
                if (flow_rd.present && flow_rd.count != 8'd0) begin
                  flow_we          = 1'b1;
                  flow_wdata.count = flow_rd.count - 8'd1;
                end
              end
            end
            FUNC_QUERY: begin
              res.flow_count = flow_rd.present ? flow_rd.count : 8'd0;
            end
            default: begin
              res.status = STATUS_OK;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    res.flows_seen = present_total_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_LIMIT_MODE:  cfg_prdata = {31'd0, limit_mode_r};
      REG_MAX_PACKETS: cfg_prdata = {24'd0, max_packets_r};
      REG_MAX_BYTES:   cfg_prdata = {8'd0, max_bytes_r};
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLEAR;
      clr_idx_r       <= '0;
      head_r          <= '0;
      tail_r          <= '0;
      stored_r        <= '0;
      bytes_r         <= '0;
      present_total_r <= '0;
      out_valid_r     <= 1'b0;
      limit_mode_r    <= LIMIT_PACKETS;
      max_packets_r   <= RST_MAX_PACKETS;
      max_bytes_r     <= RST_MAX_BYTES;
    end else begin
      state_r         <= state_nxt;
      clr_idx_r       <= clr_idx_nxt;
      head_r          <= head_nxt;
      tail_r          <= tail_nxt;
      stored_r        <= stored_nxt;
      bytes_r         <= bytes_nxt;
      present_total_r <= present_total_nxt;
      out_valid_r     <= out_valid_nxt;
      if (cfg_write) begin
        case (cfg_paddr[3:2])
          REG_LIMIT_MODE:  limit_mode_r  <= cfg_pwdata[0];
          REG_MAX_PACKETS: max_packets_r <= cfg_pwdata[7:0];
          REG_MAX_BYTES:   max_bytes_r   <= cfg_pwdata[23:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (flow_re) begin
      flow_idx_r <= flow_raddr;
    end
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/dtq_checker.sv */
// Port-level checker of the drop-tail queue top level, with its bind statement.
module dtq_checker
  import dtq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  logic [6:0] last_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seen_r <= '0;
    end else if (out_valid && !out_stall) begin
      last_seen_r <= out_data.flows_seen;
    end
  end

  a_stall_after_reset: assert property (@(posedge clk)
    disable iff (!rst_n) $past(!rst_n) |-> in_stall)
    else $error("Input word taken during the clearing pass.");

  a_desc_fields_only_on_pop: assert property (@(posedge clk)
    disable iff (!rst_n) out_valid && out_data.status != STATUS_OK |->
      out_data.out_tag == '0 && out_data.out_length == '0 && out_data.out_flow == '0)
    else $error("Descriptor fields set on a word that popped nothing.");

  a_flows_seen_monotonic: assert property (@(posedge clk)
    disable iff (!rst_n) out_valid |-> out_data.flows_seen >= last_seen_r)
    else $error("Distinct flow total decreased.");

  a_out_hold: assert property (@(posedge clk)
    disable iff (!rst_n) out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result word changed.");

endmodule

bind drop_tail_queue_flow_count_top dtq_checker u_dtq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
